### hw/rtl/tad_pkg.sv
`default_nettype none

package tad_pkg;

   localparam int BYTE_DELAY   = 3;
   localparam int ENABLE_DELAY = 2;
   localparam int FLASH_PERIOD = 48;
   localparam int FLASH_SHOW_FROM = 16;
   localparam int ROWS_PER_CHAR = 10;

   // glyph sets
   localparam logic [1:0] SET_ALPHA  = 2'd0;
   localparam logic [1:0] SET_CONTIG = 2'd1;
   localparam logic [1:0] SET_SEPAR  = 2'd2;

   // serial attribute control codes
   localparam logic [6:0] CTL_ALPHA_FIRST  = 7'd1;
   localparam logic [6:0] CTL_ALPHA_LAST   = 7'd7;
   localparam logic [6:0] CTL_FLASH_ON     = 7'd8;
   localparam logic [6:0] CTL_FLASH_OFF    = 7'd9;
   localparam logic [6:0] CTL_NORMAL_HT    = 7'd12;
   localparam logic [6:0] CTL_DOUBLE_HT    = 7'd13;
   localparam logic [6:0] CTL_MOSAIC_FIRST = 7'd17;
   localparam logic [6:0] CTL_MOSAIC_LAST  = 7'd23;
   localparam logic [6:0] CTL_CONCEAL      = 7'd24;
   localparam logic [6:0] CTL_CONTIGUOUS   = 7'd25;
   localparam logic [6:0] CTL_SEPARATED    = 7'd26;
   localparam logic [6:0] CTL_BLACK_BG     = 7'd28;
   localparam logic [6:0] CTL_NEW_BG       = 7'd29;
   localparam logic [6:0] CTL_HOLD_ON      = 7'd30;
   localparam logic [6:0] CTL_HOLD_OFF     = 7'd31;
   localparam logic [6:0] CHAR_FIRST       = 7'h20;

   localparam logic [2:0] COLOR_WHITE = 3'd7;
   localparam logic [2:0] COLOR_BLACK = 3'd0;

   // CSR register indexes (byte address bit 2)
   localparam logic CSR_INTERLACE = 1'b0;
   localparam logic CSR_SINGLE    = 1'b1;

   typedef struct packed {
      logic [1:0] glyph_set;
      logic [6:0] code;
   } glyph_type;

   localparam glyph_type SPACE_GLYPH = '{glyph_set: SET_ALPHA, code: 7'd0};

   typedef struct packed {
      logic       row_address_odd;
      logic       frame_start;
      logic       display_enable;
      logic [6:0] data_byte;
   } item_type;

   typedef struct packed {
      logic       interlace_sync_video;
      logic       single_output_mode;
   } cfg_type;

   // packed from bit 0 upward: display_on first
   typedef struct packed {
      logic [2:0] back_color;
      logic [2:0] fore_color;
      logic [4:0] next_glyph_row;
      logic [4:0] glyph_row;
      logic [6:0] glyph_code;
      logic [1:0] glyph_set;
      logic       display_on;
   } result_type;

endpackage

`default_nettype wire

### hw/rtl/tad_core.sv
`default_nettype none

module tad_core
   import tad_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         advance,
   input  item_type    item,
   input  cfg_type     cfg,
   output result_type  result
);

   logic [6:0] byte_dly_ff [BYTE_DELAY];
   logic       en_dly_ff   [ENABLE_DELAY];
   logic       en_now_ff, en_now_in;
   logic [3:0] row_ff, row_in;
   logic [5:0] flash_cnt_ff, flash_cnt_in;
   logic       flash_shown_ff, flash_shown_in;
   logic       mosaic_ff, mosaic_in;
   logic       separated_ff, separated_in;
   logic       double_ff, double_in;
   logic       flash_ff, flash_in;
   logic       dbl_seen_ff, dbl_seen_in;
   logic       lower_ff, lower_in;
   logic [2:0] fg_ff, fg_in;
   logic [2:0] bg_ff, bg_in;
   logic       hold_ff, hold_in;
   glyph_type  held_ff, held_in;
   glyph_type  shown_ff, shown_in;
   logic [2:0] shown_fg_ff, shown_fg_in;

   always_comb begin
      logic [6:0] head;
      logic       head_en;
      logic [5:0] flash_inc;
      logic [3:0] row_step;
      glyph_type  g;
      glyph_type  glyph;
      logic [4:0] grow;
      logic [4:0] nrow;

      en_now_in      = en_now_ff;
      row_in         = row_ff;
      flash_cnt_in   = flash_cnt_ff;
      flash_shown_in = flash_shown_ff;
      mosaic_in      = mosaic_ff;
      separated_in   = separated_ff;
      double_in      = double_ff;
      flash_in       = flash_ff;
      dbl_seen_in    = dbl_seen_ff;
      lower_in       = lower_ff;
      fg_in          = fg_ff;
      bg_in          = bg_ff;
      hold_in        = hold_ff;
      held_in        = held_ff;
      shown_in       = shown_ff;
      shown_fg_in    = shown_fg_ff;

      head    = byte_dly_ff[0];
      head_en = en_dly_ff[0];
      g       = SPACE_GLYPH;

      // new frame comes before the byte
      flash_inc = flash_cnt_ff + 6'd1;
      if (item.frame_start) begin
         row_in   = '0;
         lower_in = 1'b0;
         flash_cnt_in = (flash_inc >= 6'(FLASH_PERIOD)) ? 6'd0 : flash_inc;
         flash_shown_in = (flash_cnt_in >= 6'(FLASH_SHOW_FROM));
      end

      if (head_en) begin
         shown_fg_in = fg_ff;
         if (head >= CHAR_FIRST) begin
            g.glyph_set = !mosaic_ff ? SET_ALPHA : (separated_ff ? SET_SEPAR : SET_CONTIG);
            g.code      = head - CHAR_FIRST;
            shown_in    = g;
            if (mosaic_ff) begin
               if (head[5]) held_in = g;
            end else begin
               held_in = SPACE_GLYPH;
            end
         end else begin
            if (head inside {[CTL_ALPHA_FIRST:CTL_ALPHA_LAST]}) begin
               mosaic_in = 1'b0;
               fg_in     = head[2:0];
            end else if (head inside {[CTL_MOSAIC_FIRST:CTL_MOSAIC_LAST]}) begin
               mosaic_in = 1'b1;
               fg_in     = head[2:0];
            end else begin
               case (head)
                  CTL_FLASH_ON:   flash_in = 1'b1;
                  CTL_FLASH_OFF:  flash_in = 1'b0;
                  CTL_NORMAL_HT:  double_in = 1'b0;
                  CTL_DOUBLE_HT: begin
                     double_in   = 1'b1;
                     dbl_seen_in = 1'b1;
                  end
                  CTL_CONCEAL: begin
                     fg_in       = bg_ff;
                     shown_fg_in = bg_ff;
                  end
                  CTL_CONTIGUOUS: separated_in = 1'b0;
                  CTL_SEPARATED:  separated_in = 1'b1;
                  CTL_BLACK_BG:   bg_in = COLOR_BLACK;
                  CTL_NEW_BG:     bg_in = fg_ff;
                  CTL_HOLD_ON:    hold_in = 1'b1;
                  CTL_HOLD_OFF:   hold_in = 1'b0;
                  default: ;
               endcase
            end
            // held mosaic survives a control code unless height changes
            if (mosaic_ff && (hold_ff || hold_in) && (double_in == double_ff)) begin
               shown_in = held_ff;
            end else begin
               shown_in = SPACE_GLYPH;
               held_in  = SPACE_GLYPH;
            end
         end
      end

      // falling edge of delayed enable ends the scanline
      row_step = row_in + 4'd1;
      if (!head_en && en_now_ff) begin
         mosaic_in    = 1'b0;
         separated_in = 1'b0;
         double_in    = 1'b0;
         flash_in     = 1'b0;
         fg_in        = COLOR_WHITE;
         bg_in        = COLOR_BLACK;
         hold_in      = 1'b0;
         held_in      = SPACE_GLYPH;
         row_in       = row_step;
         if (row_step == 4'(ROWS_PER_CHAR)) begin
            row_in = '0;
            if (lower_in) lower_in = 1'b0;
            else if (dbl_seen_ff) lower_in = 1'b1;
         end
         dbl_seen_in = 1'b0;
      end
      en_now_in = head_en;

      glyph = shown_in;
      if ((flash_in && !flash_shown_in) || (lower_in && !double_in))
         glyph = SPACE_GLYPH;

      if (!double_in) grow = {row_in, 1'b0};
      else if (lower_in) grow = {1'b0, row_in} + 5'(ROWS_PER_CHAR);
      else grow = {1'b0, row_in};
      if (item.row_address_odd && !double_in
          && (!cfg.interlace_sync_video || cfg.single_output_mode))
         grow = grow + 5'd1;
      nrow = grow;
      if (!cfg.single_output_mode && cfg.interlace_sync_video && !double_in)
         nrow = grow + 5'd1;

      if (head_en) begin
         result.display_on     = 1'b1;
         result.glyph_set      = glyph.glyph_set;
         result.glyph_code     = glyph.code;
         result.glyph_row      = grow;
         result.next_glyph_row = nrow;
         result.fore_color     = shown_fg_in;
         result.back_color     = bg_in;
      end else begin
         result = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BYTE_DELAY; i++) byte_dly_ff[i] <= '0;
         for (int i = 0; i < ENABLE_DELAY; i++) en_dly_ff[i] <= 1'b0;
         en_now_ff      <= 1'b0;
         row_ff         <= '0;
         flash_cnt_ff   <= 6'd1;
         flash_shown_ff <= 1'b0;
         mosaic_ff      <= 1'b0;
         separated_ff   <= 1'b0;
         double_ff      <= 1'b0;
         flash_ff       <= 1'b0;
         dbl_seen_ff    <= 1'b0;
         lower_ff       <= 1'b0;
         fg_ff          <= COLOR_WHITE;
         bg_ff          <= COLOR_BLACK;
         hold_ff        <= 1'b0;
         held_ff        <= SPACE_GLYPH;
         shown_ff       <= SPACE_GLYPH;
         shown_fg_ff    <= '0;
      end else if (advance) begin
         for (int i = 0; i < BYTE_DELAY - 1; i++) byte_dly_ff[i] <= byte_dly_ff[i + 1];
         byte_dly_ff[BYTE_DELAY - 1] <= item.data_byte;
         for (int i = 0; i < ENABLE_DELAY - 1; i++) en_dly_ff[i] <= en_dly_ff[i + 1];
         en_dly_ff[ENABLE_DELAY - 1] <= item.display_enable;
         en_now_ff      <= en_now_in;
         row_ff         <= row_in;
         flash_cnt_ff   <= flash_cnt_in;
         flash_shown_ff <= flash_shown_in;
         mosaic_ff      <= mosaic_in;
         separated_ff   <= separated_in;
         double_ff      <= double_in;
         flash_ff       <= flash_in;
         dbl_seen_ff    <= dbl_seen_in;
         lower_ff       <= lower_in;
         fg_ff          <= fg_in;
         bg_ff          <= bg_in;
         hold_ff        <= hold_in;
         held_ff        <= held_in;
         shown_ff       <= shown_in;
         shown_fg_ff    <= shown_fg_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/teletext_attribute_decoder.sv
`default_nettype none

// Teletext serial-attribute decoder, one character word per clock while the receiver keeps up.
// req_ channel: one word per character clock of the display timing with the
// character byte, the display-enable level, a frame-start flag and the low
// raster-row bit. rsp_ channel: one word per input word with display_on,
// glyph set, glyph code, the glyph rows of both output lines and the colors.
// The byte runs through a 3-word delay and display enable a 2-word delay,
// counted in accepted words, not cycles.
// An accepted word waits in the input register, is decoded combinationally and
// its result is loaded into the result register that drives rsp_tvalid.
// Throughput: one word per cycle while rsp_tready stays high, set by the single
// decode stage between the input register and the result register.
// csr_ port: register 0 (byte address 0) interlace_sync_video, register 1
// (byte address 4) single_output_mode; write only while no word is in flight.
// Reset: attributes return to white on black alphanumerics, the delays and
// row counter clear, the flash counter starts at 1, both CSRs clear.
// When the receiver stalls, the result register holds and the input register
// fills; req_tready then drops until rsp_tready returns.

module teletext_attribute_decoder
   import tad_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,  // data_byte[6:0], display_enable, frame_start, row_address_odd
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,  // display_on, glyph_set[2], glyph_code[7], glyph_row[5],
                                   // next_glyph_row[5], fore_color[3], back_color[3]
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic       in_valid_ff;
   item_type   in_item_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type result;
   cfg_type    cfg_ff;
   logic       advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_ff};
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_paddr[2])
         CSR_INTERLACE: csr_prdata = {31'd0, cfg_ff.interlace_sync_video};
         CSR_SINGLE:    csr_prdata = {31'd0, cfg_ff.single_output_mode};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         if (csr_paddr[2] == CSR_INTERLACE) cfg_ff.interlace_sync_video <= csr_pwdata[0];
         else cfg_ff.single_output_mode <= csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (advance) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.data_byte       <= req_tdata[6:0];
         in_item_ff.display_enable  <= req_tdata[8];
         in_item_ff.frame_start     <= req_tdata[9];
         in_item_ff.row_address_odd <= req_tdata[10];
      end
      if (advance) out_ff <= result;
   end

   tad_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

endmodule

`default_nettype wire

### tb/teletext_attribute_decoder_tb.sv
`timescale 1ns / 1ps

import tad_pkg::*;

// Tracks the decoder's attribute state word by word and checks each result word.
class tad_glyph_tracker;
   // settings
   bit interlace;
   bit single_line;

   // mirrored decoder state
   logic [6:0] char_pipe [BYTE_DELAY];
   logic       enable_pipe [ENABLE_DELAY];
   logic       enable_now;
   logic [3:0] row_cnt;
   logic [5:0] flash_cnt;
   logic       flash_visible;
   logic       mosaic;
   logic       separated;
   logic       dbl_height;
   logic       flashing;
   logic       dbl_seen;
   logic       lower_row;
   logic [2:0] fg;
   logic [2:0] bg;
   logic       hold;
   glyph_type  held;
   glyph_type  shown;
   logic [2:0] shown_fg;

   result_type glyph_queue [$];
   int unsigned errors;
   int unsigned results_checked;
   int unsigned lower_row_words;
   int unsigned flash_hidden_words;

   function new();
      interlace = 0;
      single_line = 0;
      for (int i = 0; i < BYTE_DELAY; i++) char_pipe[i] = '0;
      for (int i = 0; i < ENABLE_DELAY; i++) enable_pipe[i] = 1'b0;
      enable_now = 0;
      row_cnt = '0;
      flash_cnt = 6'd1;
      flash_visible = 0;
      mosaic = 0;
      separated = 0;
      dbl_height = 0;
      flashing = 0;
      dbl_seen = 0;
      lower_row = 0;
      fg = COLOR_WHITE;
      bg = COLOR_BLACK;
      hold = 0;
      held = SPACE_GLYPH;
      shown = '0;
      shown_fg = '0;
      errors = 0;
      results_checked = 0;
      lower_row_words = 0;
      flash_hidden_words = 0;
   endfunction

   function void set_cfg(logic idx, logic [31:0] value);
      if (idx == CSR_INTERLACE) interlace = value[0];
      else single_line = value[0];
   endfunction

   function int unsigned pending();
      return glyph_queue.size();
   endfunction

   task report_mismatch(string what);
      errors++;
      if (errors <= 40) $display("[%0t] ERROR %s", $realtime, what);
   endtask

   function logic [1:0] active_set();
      if (!mosaic) return SET_ALPHA;
      return separated ? SET_SEPAR : SET_CONTIG;
   endfunction

   function void end_scanline();
      mosaic = 0;
      separated = 0;
      dbl_height = 0;
      flashing = 0;
      fg = COLOR_WHITE;
      bg = COLOR_BLACK;
      hold = 0;
      held = SPACE_GLYPH;
      row_cnt = row_cnt + 4'd1;
      if (row_cnt == ROWS_PER_CHAR) begin
         row_cnt = '0;
         if (lower_row) lower_row = 0;
         else if (dbl_seen) lower_row = 1;
      end
      dbl_seen = 0;
   endfunction

   function void start_frame();
      row_cnt = '0;
      lower_row = 0;
      flash_cnt = flash_cnt + 6'd1;
      if (flash_cnt >= FLASH_PERIOD) flash_cnt = '0;
      flash_visible = (flash_cnt >= FLASH_SHOW_FROM);
   endfunction

   function void apply_control(logic [6:0] c);
      if (c >= CTL_ALPHA_FIRST && c <= CTL_ALPHA_LAST) begin
         mosaic = 0;
         fg = c[2:0];
      end else if (c >= CTL_MOSAIC_FIRST && c <= CTL_MOSAIC_LAST) begin
         mosaic = 1;
         fg = c[2:0];
      end else begin
         case (c)
            CTL_FLASH_ON:   flashing = 1;
            CTL_FLASH_OFF:  flashing = 0;
            CTL_NORMAL_HT:  dbl_height = 0;
            CTL_DOUBLE_HT: begin
               dbl_height = 1;
               dbl_seen = 1;
            end
            CTL_CONCEAL: begin
               fg = bg;
               shown_fg = fg;
            end
            CTL_CONTIGUOUS: separated = 0;
            CTL_SEPARATED:  separated = 1;
            CTL_BLACK_BG:   bg = COLOR_BLACK;
            CTL_NEW_BG:     bg = fg;
            CTL_HOLD_ON:    hold = 1;
            CTL_HOLD_OFF:   hold = 0;
            default: ;
         endcase
      end
   endfunction

   function void take_char(logic [6:0] d);
      logic      hold_prior;
      glyph_type g;
      glyph_type prev_held;
      logic      prev_mosaic;
      logic      prev_dbl;
      hold_prior = hold;
      shown_fg = fg;
      if (d >= CHAR_FIRST) begin
         g.glyph_set = active_set();
         g.code = d - CHAR_FIRST;
         shown = g;
         if (mosaic) begin
            if (d[5]) held = g;
         end else begin
            held = SPACE_GLYPH;
         end
      end else begin
         prev_held = held;
         prev_mosaic = mosaic;
         prev_dbl = dbl_height;
         apply_control(d);
         hold_prior = hold_prior | hold;
         // held mosaic stays visible across controls unless the height changes
         if (prev_mosaic && hold_prior && dbl_height == prev_dbl) begin
            shown = prev_held;
         end else begin
            shown = SPACE_GLYPH;
            held = SPACE_GLYPH;
         end
      end
   endfunction

   // one accepted word in, one expected result out
   function void note_input(logic [15:0] w);
      logic [6:0] head_char;
      logic       head_en;
      logic [4:0] row;
      logic [4:0] next_row;
      glyph_type  g;
      result_type r;
      if (w[9]) start_frame();
      head_char = char_pipe[0];
      head_en = enable_pipe[0];
      if (head_en) take_char(head_char);
      for (int i = 0; i < BYTE_DELAY - 1; i++) char_pipe[i] = char_pipe[i + 1];
      char_pipe[BYTE_DELAY - 1] = w[6:0];
      if (!head_en && enable_now) end_scanline();
      enable_now = head_en;
      for (int i = 0; i < ENABLE_DELAY - 1; i++) enable_pipe[i] = enable_pipe[i + 1];
      enable_pipe[ENABLE_DELAY - 1] = w[8];

      r = '0;
      if (enable_now) begin
         g = shown;
         if ((flashing && !flash_visible) || (lower_row && !dbl_height)) begin
            g = SPACE_GLYPH;
            if (flashing && !flash_visible) flash_hidden_words++;
         end
         if (lower_row) lower_row_words++;
         row = {1'b0, row_cnt};
         if (!dbl_height) row = row * 5'd2;
         else if (lower_row) row = row + 5'd10;
         if (w[10] && !dbl_height && (!interlace || single_line)) row = row + 5'd1;
         next_row = row;
         if (!single_line && interlace && !dbl_height) next_row = row + 5'd1;
         r.display_on = 1'b1;
         r.glyph_set = g.glyph_set;
         r.glyph_code = g.code;
         r.glyph_row = row;
         r.next_glyph_row = next_row;
         r.fore_color = shown_fg;
         r.back_color = bg;
      end
      glyph_queue.push_back(r);
   endfunction

   task check_field(string name, int got, int want);
      if (got != want)
         report_mismatch($sformatf("%s: got %0d, want %0d (result %0d)",
                                   name, got, want, results_checked));
   endtask

   task check_result(logic [31:0] d);
      result_type got;
      result_type want;
      if (glyph_queue.size() == 0) begin
         report_mismatch($sformatf("result word %h with nothing outstanding", d));
      end else begin
         want = glyph_queue.pop_front();
         got = d[$bits(result_type)-1:0];
         check_field("display_on", int'(got.display_on), int'(want.display_on));
         check_field("glyph_set", int'(got.glyph_set), int'(want.glyph_set));
         check_field("glyph_code", int'(got.glyph_code), int'(want.glyph_code));
         check_field("glyph_row", int'(got.glyph_row), int'(want.glyph_row));
         check_field("next_glyph_row", int'(got.next_glyph_row),
                     int'(want.next_glyph_row));
         check_field("fore_color", int'(got.fore_color), int'(want.fore_color));
         check_field("back_color", int'(got.back_color), int'(want.back_color));
         check_field("pad bits", int'(d[31:$bits(result_type)]), 0);
      end
      results_checked++;
   endtask
endclass

module teletext_attribute_decoder_tb;

   localparam logic [6:0] CTL_UNUSED_NUL = 7'd0;
   localparam int RANDOM_WORDS = 1850;
   localparam int NUM_PHASES = 4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   tad_glyph_tracker sb;
   bit          steady = 1'b0;
   int unsigned words_sent = 0;
   int unsigned phase_end = 0;
   int unsigned scanlines = 0;
   int unsigned frames = 0;
   int unsigned rx_stall = 0;
   int unsigned rx_gap;

   teletext_attribute_decoder u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("teletext_attribute_decoder: mismatch");
      $finish;
   end

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 25);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_stall <= 0;
      end else if (rx_stall != 0) begin
         rsp_tready <= 1'b0;
         rx_stall <= rx_stall - 1;
      end else begin
         rx_gap = pick_gap();
         if (rx_gap == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            rx_stall <= rx_gap - 1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_input(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   task send_word(input logic [7:0] data, input logic en, input logic fs, input logic ra);
      int unsigned gap;
      req_tdata <= {5'b0, ra, fs, en, data};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task csr_write(input logic idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.set_cfg(idx, value);
   endtask

   // hold off until every outstanding result is back and the pipe is empty
   task drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_char();
      int unsigned r;
      logic [6:0] c;
      r = $urandom_range(0, 99);
      if (r < 6) c = 7'($urandom_range(CTL_MOSAIC_FIRST, CTL_MOSAIC_LAST));
      else if (r < 9) c = $urandom_range(0, 1) ? CTL_HOLD_ON : CTL_HOLD_OFF;
      else if (r < 12) c = $urandom_range(0, 1) ? CTL_DOUBLE_HT : CTL_NORMAL_HT;
      else if (r < 38) c = 7'($urandom_range(0, CHAR_FIRST - 1));
      else c = 7'($urandom_range(CHAR_FIRST, 127));
      return {1'($urandom_range(0, 1)), c};
   endfunction

   task random_frame();
      int unsigned r;
      int unsigned lines;
      int unsigned n_on;
      int unsigned n_off;
      logic        fs;
      logic        ra;
      r = $urandom_range(0, 99);
      if (r < 50) lines = $urandom_range(1, 2);
      else if (r < 75) lines = $urandom_range(3, 9);
      else lines = $urandom_range(10, 24);
      fs = 1'b1;
      frames++;
      for (int l = 0; l < lines && words_sent < phase_end; l++) begin
         ra = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 99) < 12) begin
            // noise: every field random
            n_on = $urandom_range(1, 8);
            for (int k = 0; k < n_on; k++) begin
               send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         fs | ($urandom_range(0, 99) < 20), 1'($urandom_range(0, 1)));
               fs = 1'b0;
            end
         end else begin
            n_on = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(2, 10);
            n_off = $urandom_range(1, 4);
            for (int k = 0; k < n_on; k++) begin
               send_word(pick_char(), 1'b1, fs, ra);
               fs = 1'b0;
            end
            for (int k = 0; k < n_off; k++) send_word(pick_char(), 1'b0, 1'b0, ra);
            scanlines++;
         end
      end
   endtask

   initial begin
      logic [7:0]  directed [18] = '{
         8'hFF, {1'b0, CHAR_FIRST}, {1'b1, CTL_UNUSED_NUL}, {1'b0, CTL_MOSAIC_FIRST},
         8'h3F, {1'b0, CTL_HOLD_ON}, {1'b0, CTL_SEPARATED}, 8'h60,
         {1'b0, CTL_NEW_BG}, {1'b0, CTL_CONCEAL}, {1'b0, CTL_FLASH_ON},
         {1'b0, CTL_DOUBLE_HT}, {1'b0, CTL_NORMAL_HT}, {1'b1, CTL_HOLD_OFF},
         {1'b0, CTL_CONTIGUOUS}, {1'b0, CTL_BLACK_BG}, {1'b0, CTL_FLASH_OFF},
         {1'b0, CTL_ALPHA_LAST}};
      logic [31:0] interlace_vals [NUM_PHASES] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFE};
      logic [31:0] single_vals [NUM_PHASES] = '{32'h0, 32'h0, 32'h1, 32'h7FFF_FFFF};

      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: one scanline through every attribute class, then a blank
      send_word(8'h00, 1'b0, 1'b1, 1'b0);
      frames++;
      foreach (directed[i]) send_word(directed[i], 1'b1, 1'b0, i[0]);
      send_word(8'h41, 1'b0, 1'b0, 1'b1);
      send_word(8'h41, 1'b0, 1'b0, 1'b1);
      send_word(8'hC1, 1'b1, 1'b1, 1'b1);
      scanlines++;

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         csr_write(CSR_INTERLACE, interlace_vals[p]);
         csr_write(CSR_SINGLE, single_vals[p]);
         steady = (p == 1);
         phase_end = words_sent + RANDOM_WORDS / NUM_PHASES;
         while (words_sent < phase_end) random_frame();
      end
      steady = 1'b0;

      drain();
      repeat (8) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
      $display("covered %0d words, %0d scanlines, %0d frames, %0d results checked",
               words_sent, scanlines, frames, sb.results_checked);
      $display("all four row-mode settings; %0d words on lower double rows, %0d flash-hidden",
               sb.lower_row_words, sb.flash_hidden_words);
      if (sb.errors == 0) begin
         $display("teletext_attribute_decoder: match");
      end else begin
         $display("teletext_attribute_decoder: mismatch");
      end
      $finish;
   end

endmodule
